// ===== rtl/core/bitmap_page_frame_allocator_defines.svh =====
// assertion macros used by the checker
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BPFA_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bpfa assertion failed");

// next-cycle implication, disabled during reset
`define BPFA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bpfa assertion failed");

`endif

// ===== rtl/core/bpfa_pkg.sv =====
// shared constants, codes and types of the bitmap page frame allocator
package bpfa_pkg;

    // block map geometry; blocks scan in ascending block order
    localparam int NUM_BLOCKS = 64;
    localparam int BLK_W      = $clog2(NUM_BLOCKS);
    localparam int CNT_W      = BLK_W + 1;
    localparam int MAX_JOBS   = 16;
    localparam int JOB_W      = $clog2(MAX_JOBS);

    // input and result field widths
    localparam int ACT_W  = 2;
    localparam int STAT_W = 3;

    // configuration port
    localparam int DATA_W = 64;
    localparam int ADDR_W = 4;
    localparam logic REG_PRESET_IDX = 1'b0;

    // reset values
    localparam logic [DATA_W-1:0] PRESET_RESET = 64'h0000_0000_8100_2A73;
    localparam logic [CNT_W-1:0]  FREE_RESET   = 7'd54;

    // action codes
    localparam logic [ACT_W-1:0] ACT_INIT  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FREE  = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_TOO_FEW   = 3'd1;
    localparam logic [STAT_W-1:0] ST_UNKNOWN   = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_JOBS   = 3'd3;
    localparam logic [STAT_W-1:0] ST_ID_IN_USE = 3'd4;

    // one result beat
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              block_valid;
        logic [BLK_W-1:0]  page_idx;
        logic [BLK_W-1:0]  block_idx;
        logic [CNT_W-1:0]  free_count;
        logic              last;
    } result_t;

    // owner memory access from the sequencer
    typedef struct packed {
        logic             we;
        logic [BLK_W-1:0] waddr;
        logic [JOB_W-1:0] wdata;
        logic             re;
        logic [BLK_W-1:0] raddr;
    } ram_req_t;

endpackage

// ===== rtl/core/bitmap_page_frame_allocator.sv =====
// top level of the bitmap page frame allocator
// One request at a time: s_ready is high only while the block is idle. A single scan counter
// walks the 64 blocks. Init reloads the map from the preset before its one beat; allocate
// scans upward and emits a beat on each claim; free visits each block in a read state and
// then a check state (the owner tag memory has a registered read) and ends with a last beat;
// rejected requests and zero-block allocates give their status beat from the response state
// once the result register is free. Action 3 is taken and dropped.
// The result register lets the scan go on while a beat waits on m_ready; the scan pauses only
// when a new beat finds the register still full. Blocks are claimed lowest first and released
// in ascending order. The preset map sits in one 64-bit register at address 0.
module bitmap_page_frame_allocator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bpfa_pkg::ACT_W-1:0]    s_action,
    input  logic [bpfa_pkg::JOB_W-1:0]    s_job_id,
    input  logic [bpfa_pkg::CNT_W-1:0]    s_block_count,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bpfa_pkg::STAT_W-1:0]   m_status,
    output logic                          m_block_valid,
    output logic [bpfa_pkg::BLK_W-1:0]    m_page_idx,
    output logic [bpfa_pkg::BLK_W-1:0]    m_block_idx,
    output logic [bpfa_pkg::CNT_W-1:0]    m_free_count,
    output logic                          m_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpfa_pkg::ADDR_W-1:0]   paddr,
    input  logic [bpfa_pkg::DATA_W-1:0]   pwdata,
    output logic [bpfa_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [bpfa_pkg::DATA_W-1:0] preset;
    bpfa_pkg::ram_req_t          ram_req;
    logic [bpfa_pkg::JOB_W-1:0]  ram_rdata;
    bpfa_pkg::result_t           m_res;

    // configuration registers
    bpfa_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .preset  (preset)
    );

    // owner tags
    bpfa_owner_ram u_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // sequencer and scan
    bpfa_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_job_id      (s_job_id),
        .s_block_count (s_block_count),
        .preset        (preset),
        .ram_req       (ram_req),
        .ram_rdata     (ram_rdata),
        .m_res         (m_res),
        .m_valid       (m_valid),
        .m_ready       (m_ready)
    );

    // result beat fields
    assign m_status      = m_res.status;
    assign m_block_valid = m_res.block_valid;
    assign m_page_idx    = m_res.page_idx;
    assign m_block_idx   = m_res.block_idx;
    assign m_free_count  = m_res.free_count;
    assign m_last        = m_res.last;

endmodule

// ===== rtl/core/bpfa_cfg_regs.sv =====
// apb register file holding the preset occupancy map
module bpfa_cfg_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bpfa_pkg::ADDR_W-1:0] paddr,
    input  logic [bpfa_pkg::DATA_W-1:0] pwdata,
    output logic [bpfa_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output logic [bpfa_pkg::DATA_W-1:0] preset
);

    logic [bpfa_pkg::DATA_W-1:0] preset_reg;
    logic [bpfa_pkg::DATA_W-1:0] preset_next;
    logic                        sel_preset;

    // register decode on the 8-byte slot
    assign sel_preset = (paddr[bpfa_pkg::ADDR_W-1] == bpfa_pkg::REG_PRESET_IDX);

    // write on the access phase
    always_comb begin
        preset_next = preset_reg;
        if (psel && penable && pwrite && pready && sel_preset) begin
            preset_next = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            preset_reg <= bpfa_pkg::PRESET_RESET;
        end else begin
            preset_reg <= preset_next;
        end
    end

    // read back
    assign prdata = sel_preset ? preset_reg : '0;
    assign pready = 1'b1;
    assign preset = preset_reg;

endmodule

// ===== rtl/core/bpfa_owner_ram.sv =====
// owner tag memory, one write and one registered read port
module bpfa_owner_ram (
    input  logic                        aclk,
    input  bpfa_pkg::ram_req_t          req,
    output logic [bpfa_pkg::JOB_W-1:0]  rdata
);

    logic [bpfa_pkg::JOB_W-1:0] mem [bpfa_pkg::NUM_BLOCKS];
    logic [bpfa_pkg::JOB_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge aclk) begin
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/bpfa_seq.sv =====
// sequencer with the shared block scan unit, map state and result register
module bpfa_seq (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [bpfa_pkg::ACT_W-1:0]   s_action,
    input  logic [bpfa_pkg::JOB_W-1:0]   s_job_id,
    input  logic [bpfa_pkg::CNT_W-1:0]   s_block_count,
    input  logic [bpfa_pkg::DATA_W-1:0]  preset,
    output bpfa_pkg::ram_req_t           ram_req,
    input  logic [bpfa_pkg::JOB_W-1:0]   ram_rdata,
    output bpfa_pkg::result_t            m_res,
    output logic                         m_valid,
    input  logic                         m_ready
);

    localparam int BLK_W = bpfa_pkg::BLK_W;
    localparam int CNT_W = bpfa_pkg::CNT_W;
    localparam int NB    = bpfa_pkg::NUM_BLOCKS;
    localparam int NJ    = bpfa_pkg::MAX_JOBS;
    localparam logic [BLK_W-1:0] LAST_IDX = BLK_W'(NB - 1);

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INIT     = 3'd1;
    localparam logic [2:0] S_RESP     = 3'd2;
    localparam logic [2:0] S_ALLOC    = 3'd3;
    localparam logic [2:0] S_FREE_RD  = 3'd4;
    localparam logic [2:0] S_FREE_CHK = 3'd5;
    localparam logic [2:0] S_FLUSH    = 3'd6;

    logic [2:0]                  state_reg, state_next;
    logic [BLK_W-1:0]            idx_reg, idx_next;
    logic [BLK_W-1:0]            page_reg, page_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [bpfa_pkg::JOB_W-1:0]  job_reg, job_next;
    logic [bpfa_pkg::STAT_W-1:0] status_reg, status_next;
    logic [NB-1:0]               map_reg, map_next;
    logic [NB-1:0]               held_reg, held_next;
    logic [NJ-1:0]               active_reg, active_next;
    logic [CNT_W-1:0]            free_reg, free_next;
    logic                        pend_valid_reg, pend_valid_next;
    bpfa_pkg::result_t           pend_reg, pend_next;
    bpfa_pkg::result_t           out_reg, out_next;
    logic                        out_valid_reg, out_valid_next;

    logic             can_emit;
    logic             hit;
    logic [CNT_W-1:0] free_after;

    assign can_emit   = !out_valid_reg || m_ready;
    assign hit        = held_reg[idx_reg] && (ram_rdata == job_reg);
    assign free_after = free_reg + {{(CNT_W-1){1'b0}}, map_reg[idx_reg]};

    // next-state logic
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        page_next       = page_reg;
        count_next      = count_reg;
        job_next        = job_reg;
        status_next     = status_reg;
        map_next        = map_reg;
        held_next       = held_reg;
        active_next     = active_reg;
        free_next       = free_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        ram_req         = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    job_next        = s_job_id;
                    count_next      = s_block_count;
                    idx_next        = '0;
                    page_next       = '0;
                    pend_valid_next = 1'b0;
                    unique case (s_action)
                        bpfa_pkg::ACT_INIT: begin
                            free_next   = '0;
                            held_next   = '0;
                            active_next = '0;
                            state_next  = S_INIT;
                        end
                        bpfa_pkg::ACT_ALLOC: begin
                            if (s_block_count > free_reg) begin
                                status_next = bpfa_pkg::ST_TOO_FEW;
                                state_next  = S_RESP;
                            end else if (active_reg[s_job_id]) begin
                                status_next = bpfa_pkg::ST_ID_IN_USE;
                                state_next  = S_RESP;
                            end else begin
                                active_next[s_job_id] = 1'b1;
                                if (s_block_count == '0) begin
                                    status_next = bpfa_pkg::ST_OK;
                                    state_next  = S_RESP;
                                end else begin
                                    state_next = S_ALLOC;
                                end
                            end
                        end
                        bpfa_pkg::ACT_FREE: begin
                            if (active_reg == '0) begin
                                status_next = bpfa_pkg::ST_NO_JOBS;
                                state_next  = S_RESP;
                            end else if (!active_reg[s_job_id]) begin
                                status_next = bpfa_pkg::ST_UNKNOWN;
                                state_next  = S_RESP;
                            end else begin
                                active_next[s_job_id] = 1'b0;
                                state_next = S_FREE_RD;
                            end
                        end
                        default: begin
                            // undefined action, dropped without a result
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // reload the map one block a cycle and recount the free ones
            S_INIT: begin
                map_next[idx_reg] = preset[idx_reg];
                free_next = free_reg + {{(CNT_W-1){1'b0}}, ~preset[idx_reg]};
                if (idx_reg == LAST_IDX) begin
                    status_next = bpfa_pkg::ST_OK;
                    state_next  = S_RESP;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // single status beat
            S_RESP: begin
                if (can_emit) begin
                    out_next.status      = status_reg;
                    out_next.block_valid = 1'b0;
                    out_next.page_idx    = '0;
                    out_next.block_idx   = '0;
                    out_next.free_count  = free_reg;
                    out_next.last        = 1'b1;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            // claim the lowest free blocks, one beat per claim
            S_ALLOC: begin
                if (map_reg[idx_reg]) begin
                    idx_next = idx_reg + 1'b1;
                end else if (can_emit) begin
                    map_next[idx_reg]    = 1'b1;
                    held_next[idx_reg]   = 1'b1;
                    free_next            = free_reg - 1'b1;
                    ram_req.we           = 1'b1;
                    ram_req.waddr        = idx_reg;
                    ram_req.wdata        = job_reg;
                    out_next.status      = bpfa_pkg::ST_OK;
                    out_next.block_valid = 1'b1;
                    out_next.page_idx    = page_reg;
                    out_next.block_idx   = idx_reg;
                    out_next.free_count  = free_reg - 1'b1;
                    out_next.last        = ({1'b0, page_reg} == count_reg - 1'b1);
                    out_valid_next       = 1'b1;
                    page_next            = page_reg + 1'b1;
                    idx_next             = idx_reg + 1'b1;
                    if ({1'b0, page_reg} == count_reg - 1'b1) begin
                        state_next = S_IDLE;
                    end
                end
            end

            // fetch the owner tag of the current block
            S_FREE_RD: begin
                ram_req.re    = 1'b1;
                ram_req.raddr = idx_reg;
                state_next    = S_FREE_CHK;
            end

            // release owned blocks; one is held back so the final beat can be marked
            S_FREE_CHK: begin
                if (!(hit && pend_valid_reg && !can_emit)) begin
                    if (hit) begin
                        if (pend_valid_reg) begin
                            out_next       = pend_reg;
                            out_next.last  = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        held_next[idx_reg]    = 1'b0;
                        map_next[idx_reg]     = 1'b0;
                        free_next             = free_after;
                        pend_next.status      = bpfa_pkg::ST_OK;
                        pend_next.block_valid = 1'b1;
                        pend_next.page_idx    = page_reg;
                        pend_next.block_idx   = idx_reg;
                        pend_next.free_count  = free_after;
                        pend_next.last        = 1'b0;
                        pend_valid_next       = 1'b1;
                        page_next             = page_reg + 1'b1;
                    end
                    if (idx_reg == LAST_IDX) begin
                        state_next = S_FLUSH;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_FREE_RD;
                    end
                end
            end

            // final beat of a free
            S_FLUSH: begin
                if (can_emit) begin
                    if (pend_valid_reg) begin
                        out_next = pend_reg;
                    end else begin
                        out_next.status      = bpfa_pkg::ST_OK;
                        out_next.block_valid = 1'b0;
                        out_next.page_idx    = '0;
                        out_next.block_idx   = '0;
                        out_next.free_count  = free_reg;
                    end
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            map_reg        <= bpfa_pkg::PRESET_RESET[NB-1:0];
            held_reg       <= '0;
            active_reg     <= '0;
            free_reg       <= bpfa_pkg::FREE_RESET;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            map_reg        <= map_next;
            held_reg       <= held_next;
            active_reg     <= active_next;
            free_reg       <= free_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        page_reg   <= page_next;
        count_reg  <= count_next;
        job_reg    <= job_next;
        status_reg <= status_next;
        pend_reg   <= pend_next;
        out_reg    <= out_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_res   = out_reg;
    assign m_valid = out_valid_reg;

endmodule

// ===== rtl/core/bpfa_checker.sv =====
// port-level checker for the allocator, bound to the top level
`include "bitmap_page_frame_allocator_defines.svh"

module bpfa_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [bpfa_pkg::STAT_W-1:0]   m_status,
    input logic                          m_block_valid,
    input logic [bpfa_pkg::BLK_W-1:0]    m_page_idx,
    input logic [bpfa_pkg::BLK_W-1:0]    m_block_idx,
    input logic [bpfa_pkg::CNT_W-1:0]    m_free_count,
    input logic                          m_last
);

    // no new request while a multi-beat answer is still open
    `BPFA_ASSERT_IMPL(a_busy_mid_item, aclk, aresetn, m_valid && !m_last, !s_ready)

    // a beat without a block is always the only beat of its item
    `BPFA_ASSERT_IMPL(a_empty_is_last, aclk, aresetn, m_valid && !m_block_valid,
        m_last && (m_page_idx == '0) && (m_block_idx == '0))

    // only ok beats carry blocks, and their free count never exceeds the map size
    `BPFA_ASSERT_IMPL(a_block_ok, aclk, aresetn, m_valid && m_block_valid,
        (m_status == bpfa_pkg::ST_OK) && (m_free_count <= bpfa_pkg::CNT_W'(bpfa_pkg::NUM_BLOCKS)))

    // a stalled beat stays valid and holds its block index, last flag and free count
    `BPFA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_block_idx) && $stable(m_last) && $stable(m_free_count))

endmodule

bind bitmap_page_frame_allocator bpfa_checker u_bpfa_checker (.*);
